// ===== rtl/lcdseq_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Shared types, codes and the fixed power-up table of the 4-bit character
// LCD write sequencer.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

  // Request kinds
  localparam logic [2:0] KIND_INIT   = 3'd0;
  localparam logic [2:0] KIND_NIBBLE = 3'd1;
  localparam logic [2:0] KIND_BYTE   = 3'd2;
  localparam logic [2:0] KIND_CHAR   = 3'd3;
  localparam logic [2:0] KIND_CURSOR = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAR_WAIT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_UP_WAIT = 2'd1;

  localparam logic [15:0] CHAR_WAIT_RESET     = 16'd46;
  localparam logic [15:0] POWER_UP_WAIT_RESET = 16'd15000;

  // Queued job operations
  localparam logic [1:0] OP_INIT   = 2'd0;
  localparam logic [1:0] OP_NIBBLE = 2'd1;
  localparam logic [1:0] OP_BYTE   = 2'd2;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // The power-up request emits this many steps.
  localparam int unsigned INIT_STEPS = 17;
  localparam int unsigned STEP_W     = 5;

  localparam logic [7:0] CURSOR_CMD = 8'h80;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  value;
    logic [15:0] delay_us;
    logic        row;
    logic [5:0]  column;
  } in_item_t;

  typedef struct packed {
    logic        reg_select;
    logic [3:0]  nibble;
    logic        strobe_res;
    logic [15:0] wait_us;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  op;
    logic        rs;
    logic [7:0]  data;
    logic [15:0] wait_us;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } queue_wr_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } queue_rd_t;

  typedef struct packed {
    logic [3:0]  nibble;
    logic [15:0] wait_us;
  } init_entry_t;

  // Strobed steps of the power-up sequence, following the leading wait.
  // Byte commands appear as high nibble (no wait) then low nibble.
  function automatic init_entry_t init_entry(input logic [3:0] idx);
    init_entry_t e;
    case (idx)
      4'd0:    e = '{4'h3, 16'd4100};
      4'd1:    e = '{4'h3, 16'd100};
      4'd2:    e = '{4'h0, 16'd0};
      4'd3:    e = '{4'h3, 16'd100};
      4'd4:    e = '{4'h0, 16'd0};
      4'd5:    e = '{4'h2, 16'd100};
      4'd6:    e = '{4'h2, 16'd0};
      4'd7:    e = '{4'h8, 16'd53};
      4'd8:    e = '{4'h0, 16'd0};
      4'd9:    e = '{4'h8, 16'd53};
      4'd10:   e = '{4'h0, 16'd0};
      4'd11:   e = '{4'h1, 16'd4000};
      4'd12:   e = '{4'h0, 16'd0};
      4'd13:   e = '{4'h6, 16'd53};
      4'd14:   e = '{4'h0, 16'd0};
      4'd15:   e = '{4'hF, 16'd53};
      default: e = '{4'h0, 16'd0};
    endcase
    return e;
  endfunction

endpackage

// ===== rtl/char_lcd_nibble_write_sequencer.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// Turns LCD requests into enable-strobe steps for a 4-bit character bus.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one request per beat (kind, value, delay_us, row, column).
//            in_stall rises while the job queue is full. Kinds 5 to 7 are
//            taken and dropped.
//   out_*  : one bus step per beat (reg_select, nibble, strobe_res, wait_us,
//            last); last marks the final step of a request.
//   cfg_*  : register writes, always ready. Index 0 is the character wait,
//            index 1 the power-up wait; other indexes are ignored.
// Timing: a request is written into the job queue, and its first step then
// passes from the queue head into the output register. The step sequencer
// emits one step per clock while out_stall is low; a request has 17 steps
// for power-up init, 2 for byte commands, characters and cursor moves and
// 1 for a nibble command. The queue lets further requests be taken meanwhile.
// Reset: the queue and output register empty, the character wait returns
// to 46 us and the power-up wait to 15000 us.
// While out_stall is high and a step is shown, it holds and the sequencer pauses.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer #(
  parameter int unsigned QUEUE_DEPTH = lcdseq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lcdseq_pkg::in_item_t              in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output lcdseq_pkg::out_item_t             out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lcdseq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                       cfg_data
);
  import lcdseq_pkg::*;

  queue_wr_t q_wr;
  queue_rd_t q_rd;
  logic      pop;
  logic      full;

  assign in_stall  = full;
  assign cfg_ready = 1'b1;

  lcdseq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_wr      (q_wr)
  );

  lcdseq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .pop   (pop),
    .q_rd  (q_rd),
    .full  (full)
  );

  lcdseq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rd      (q_rd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/lcdseq_front.sv =====
// ----------------------------------------------------------------------------
// lcdseq_front
// Holds the wait registers and turns each accepted request of a known kind
// into a queued job: an operation, a register-select level, a byte and a final wait.
// ----------------------------------------------------------------------------
module lcdseq_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  input  logic                                   in_stall,
  input  lcdseq_pkg::in_item_t                   in_data,
  input  logic                                   cfg_valid,
  input  logic [lcdseq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [15:0]                            cfg_data,
  output lcdseq_pkg::queue_wr_t                  q_wr
);
  import lcdseq_pkg::*;

  logic [15:0] char_wait_r;
  logic [15:0] power_up_wait_r;
  job_t        job;
  logic        known;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_wait_r     <= CHAR_WAIT_RESET;
      power_up_wait_r <= POWER_UP_WAIT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_CHAR_WAIT) begin
        char_wait_r <= cfg_data;
      end else if (cfg_index == CFG_POWER_UP_WAIT) begin
        power_up_wait_r <= cfg_data;
      end
    end
  end

  always_comb begin
    job   = '{OP_BYTE, 1'b0, in_data.value, in_data.delay_us};
    known = 1'b1;
    case (in_data.kind)
      KIND_INIT: begin
        job = '{OP_INIT, 1'b0, 8'h00, power_up_wait_r};
      end
      KIND_NIBBLE: begin
        job.op = OP_NIBBLE;
      end
      KIND_BYTE: begin
        job.op = OP_BYTE;
      end
      KIND_CHAR: begin
        job.rs      = 1'b1;
        job.wait_us = char_wait_r;
      end
      KIND_CURSOR: begin
        // Set DDRAM address: bit 7 set, row in bit 6, column below it.
        job.data    = CURSOR_CMD | {1'b0, in_data.row, in_data.column};
        job.wait_us = 16'd0;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // Unused kinds are taken from the channel but never queued.
  assign q_wr.push = in_valid && !in_stall && known;
  assign q_wr.job  = job;

endmodule

// ===== rtl/lcdseq_queue.sv =====
// ----------------------------------------------------------------------------
// lcdseq_queue
// Short job queue between the front and the step sequencer.
// ----------------------------------------------------------------------------
module lcdseq_queue #(
  parameter int unsigned DEPTH = lcdseq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lcdseq_pkg::queue_wr_t q_wr,
  input  logic                  pop,
  output lcdseq_pkg::queue_rd_t q_rd,
  output logic                  full
);
  import lcdseq_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  job_t             slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             empty;

  assign empty      = (count_r == '0);
  assign full       = (count_r == CNT_W'(DEPTH));
  assign q_rd.valid = !empty;
  assign q_rd.job   = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      slots_r[wr_ptr_r] <= q_wr.job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (q_wr.push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (q_wr.push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !q_wr.push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_wr.push && full))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("pop from an empty queue");

endmodule

// ===== rtl/lcdseq_back.sv =====
// ----------------------------------------------------------------------------
// lcdseq_back
// Step sequencer: walks the job at the head of the queue one bus step per
// cycle, while the output is not stalled, into the output register and releases the job after its last step.
// ----------------------------------------------------------------------------
module lcdseq_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lcdseq_pkg::queue_rd_t  q_rd,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output lcdseq_pkg::out_item_t  out_data
);
  import lcdseq_pkg::*;

  localparam logic [STEP_W-1:0] INIT_LAST = STEP_W'(INIT_STEPS - 1);

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  logic              out_valid_r;
  out_item_t         out_data_r;
  out_item_t         item;
  init_entry_t       entry;
  logic              can_load;
  logic              emit;

  assign can_load = !out_valid_r || !out_stall;
  assign emit     = q_rd.valid && can_load;
  assign pop      = emit && item.last;
  assign step_nxt = item.last ? '0 : step_r + 1'b1;

  always_comb begin
    entry = init_entry(4'(step_r - 1'b1));
    item  = '{q_rd.job.rs, q_rd.job.data[3:0], 1'b1, q_rd.job.wait_us, 1'b1};
    case (q_rd.job.op)
      OP_INIT: begin
        if (step_r == '0) begin
          // Leading power-up wait, no enable pulse.
          item = '{1'b0, 4'h0, 1'b0, q_rd.job.wait_us, 1'b0};
        end else begin
          item = '{1'b0, entry.nibble, 1'b1, entry.wait_us, step_r == INIT_LAST};
        end
      end
      OP_NIBBLE: begin
        item.last = 1'b1;
      end
      OP_BYTE: begin
        if (step_r == '0) begin
          item.nibble  = q_rd.job.data[7:4];
          item.wait_us = 16'd0;
          item.last    = 1'b0;
        end
      end
      default: begin
        item.last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        step_r      <= step_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= INIT_LAST)
    else $error("step counter beyond the longest sequence");

  a_step_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    step_r != '0 |-> q_rd.valid)
    else $error("sequence in progress without a job at the queue head");

  a_pop_resets_step: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> step_r == '0)
    else $error("step counter not cleared after the last step");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 4-bit character LCD write sequencer. Requests
// go in through a bursty sender. A stalling receiver takes the bus steps,
// and each step is compared with the steps that a local model of the
// sequencer predicts. Directed tests cover init, commands, characters,
// cursor moves, ignored kinds and the wait registers. Random traffic
// follows under several register settings.
// ----------------------------------------------------------------------------
module testbench;
  import lcdseq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  // Clocks to let pass after the last step, before a register write or the
  // end of the run.
  localparam int unsigned DRAIN_CYCLES = 16;

  // Indexes that decode to no register.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  // Kinds that the sequencer takes and drops.
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;

  // Power-up byte commands and the wait after each.
  logic [7:0] pwr_cmd [7] = '{8'h03, 8'h02, 8'h28, 8'h08, 8'h01, 8'h06, 8'h0F};
  logic [15:0] pwr_wait [7] = '{16'd100, 16'd100, 16'd53, 16'd53, 16'd4000, 16'd53, 16'd53};

  logic [15:0] char_wait_q;
  logic [15:0] power_up_wait_q;
  out_item_t pending_steps [$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;

  char_lcd_nibble_write_sequencer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: stretches of steady behavior, from never stalling to mostly
  // stalling, each of random length.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(3);
      stall_left <= $urandom_range(200, 10);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(3) == 0);
      2: out_stall <= ($urandom_range(1) == 1);
      default: out_stall <= ($urandom_range(9) != 0);
    endcase
  end

  // ---------------------------------------------------------------- model

  function automatic void add_step(logic rs, logic [3:0] nib, logic strobe,
                                   logic [15:0] wait_val, logic fin);
    out_item_t s;
    s.reg_select = rs;
    s.nibble = nib;
    s.strobe_res = strobe;
    s.wait_us = wait_val;
    s.last = fin;
    pending_steps.push_back(s);
  endfunction

  // Byte transfers go high nibble first; the first half carries no wait.
  function automatic void add_byte(logic rs, logic [7:0] b, logic [15:0] wait_val,
                                   logic fin);
    add_step(rs, b[7:4], 1'b1, 16'd0, 1'b0);
    add_step(rs, b[3:0], 1'b1, wait_val, fin);
  endfunction

  function automatic void predict_steps(in_item_t it);
    case (it.kind)
      KIND_INIT: begin
        add_step(1'b0, 4'h0, 1'b0, power_up_wait_q, 1'b0);
        add_step(1'b0, 4'h3, 1'b1, 16'd4100, 1'b0);
        add_step(1'b0, 4'h3, 1'b1, 16'd100, 1'b0);
        for (int i = 0; i < 7; i++)
          add_byte(1'b0, pwr_cmd[i], pwr_wait[i], i == 6);
      end
      KIND_NIBBLE: add_step(1'b0, it.value[3:0], 1'b1, it.delay_us, 1'b1);
      KIND_BYTE:   add_byte(1'b0, it.value, it.delay_us, 1'b1);
      KIND_CHAR:   add_byte(1'b1, it.value, char_wait_q, 1'b1);
      KIND_CURSOR: add_byte(1'b0, CURSOR_CMD | {1'b0, it.row, it.column}, 16'd0, 1'b1);
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- checker

  function automatic void check_field(string name, int unsigned exp_v,
                                      int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if (pending_steps.size() == 0) begin
        $display("%0t: unexpected step, expected none, actual %p", $time, out_data);
        error_count++;
      end else begin
        out_item_t exp_s;
        exp_s = pending_steps.pop_front();
        check_field("reg_select", exp_s.reg_select, out_data.reg_select);
        check_field("nibble", exp_s.nibble, out_data.nibble);
        check_field("strobe_res", exp_s.strobe_res, out_data.strobe_res);
        check_field("wait_us", exp_s.wait_us, out_data.wait_us);
        check_field("last", exp_s.last, out_data.last);
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  // Called just after a rising edge; returns just after the accepting edge.
  task automatic send_req(input in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(8, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(60, 30) : $urandom_range(12, 1);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    predict_steps(it);
  endtask

  function automatic in_item_t make_req(logic [2:0] kind, logic [7:0] value,
                                        logic [15:0] delay, logic row,
                                        logic [5:0] column);
    in_item_t it;
    it.kind = kind;
    it.value = value;
    it.delay_us = delay;
    it.row = row;
    it.column = column;
    return it;
  endfunction

  // A request of the given kind with every other field random.
  function automatic in_item_t rand_req(logic [2:0] kind);
    return make_req(kind, 8'($urandom), 16'($urandom), 1'($urandom), 6'($urandom));
  endfunction

  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Only called while idle. Drops cfg_valid again before returning.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CHAR_WAIT:     char_wait_q = data;
      CFG_POWER_UP_WAIT: power_up_wait_q = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_delay();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_power_up_init();
    send_req(rand_req(KIND_INIT));
  endtask

  task automatic test_commands();
    send_req(make_req(KIND_NIBBLE, 8'hFF, 16'hFFFF, 1'b1, 6'h3F));
    send_req(make_req(KIND_NIBBLE, 8'h00, 16'd0, 1'b0, 6'h00));
    send_req(make_req(KIND_NIBBLE, 8'hA5, 16'h5A5A, 1'b1, 6'h2A));
    send_req(make_req(KIND_BYTE, 8'h00, 16'd0, 1'b0, 6'h00));
    send_req(make_req(KIND_BYTE, 8'hFF, 16'hFFFF, 1'b1, 6'h3F));
    send_req(make_req(KIND_BYTE, 8'h5A, 16'hA5A5, 1'b0, 6'h15));
  endtask

  task automatic test_characters();
    send_req(make_req(KIND_CHAR, 8'h00, 16'hFFFF, 1'b1, 6'h3F));
    send_req(make_req(KIND_CHAR, 8'hFF, 16'd0, 1'b0, 6'h00));
    send_req(make_req(KIND_CHAR, 8'h41, 16'($urandom), 1'($urandom), 6'($urandom)));
  endtask

  // The delay field is ignored for a cursor move.
  task automatic test_cursor();
    send_req(make_req(KIND_CURSOR, 8'hFF, 16'hFFFF, 1'b0, 6'h00));
    send_req(make_req(KIND_CURSOR, 8'h00, 16'h1234, 1'b1, 6'h3F));
    send_req(make_req(KIND_CURSOR, 8'($urandom), 16'd0, 1'b0, 6'h3F));
    send_req(make_req(KIND_CURSOR, 8'($urandom), 16'($urandom), 1'b1, 6'h00));
  endtask

  task automatic test_ignored_kinds();
    for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++) begin
      send_req(rand_req(3'(k)));
      send_req(rand_req(KIND_NIBBLE));
    end
  endtask

  task automatic test_wait_registers();
    wait_idle();
    write_reg(CFG_CHAR_WAIT, 16'd0);
    write_reg(CFG_POWER_UP_WAIT, 16'd0);
    send_req(rand_req(KIND_INIT));
    send_req(rand_req(KIND_CHAR));
    wait_idle();
    write_reg(CFG_CHAR_WAIT, 16'hFFFF);
    write_reg(CFG_POWER_UP_WAIT, 16'hFFFF);
    send_req(rand_req(KIND_CHAR));
    send_req(rand_req(KIND_INIT));
    wait_idle();
    // Writes to undecoded indexes must leave both waits alone.
    write_reg(CFG_SPARE_A, 16'($urandom));
    write_reg(CFG_SPARE_B, 16'($urandom));
    send_req(rand_req(KIND_CHAR));
    send_req(rand_req(KIND_INIT));
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int unsigned r;
    logic [2:0] kind;
    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      write_reg(CFG_CHAR_WAIT, rand_delay());
      write_reg(CFG_POWER_UP_WAIT, rand_delay());
      for (int n = 0; n < 61; n++) begin
        r = $urandom_range(99);
        if (r < 6) kind = KIND_INIT;
        else if (r < 26) kind = KIND_NIBBLE;
        else if (r < 48) kind = KIND_BYTE;
        else if (r < 74) kind = KIND_CHAR;
        else if (r < 94) kind = KIND_CURSOR;
        else kind = 3'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
        send_req(make_req(kind, 8'($urandom), rand_delay(), 1'($urandom), 6'($urandom)));
      end
    end
  endtask

  initial begin
    char_wait_q = CHAR_WAIT_RESET;
    power_up_wait_q = POWER_UP_WAIT_RESET;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_CHAR_WAIT;
    cfg_data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_power_up_init();
    test_commands();
    test_characters();
    test_cursor();
    test_ignored_kinds();
    test_wait_registers();
    test_random_traffic();

    wait_idle();
    if (error_count == 0 && pending_steps.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
